### rtl/xor_delta_zero_run_encoder_assert.svh
// Assertion macros shared by the encoder RTL.
// Expects signals clk and arst_n in the including module's scope.
`ifndef XOR_DELTA_ZERO_RUN_ENCODER_ASSERT_SVH
`define XOR_DELTA_ZERO_RUN_ENCODER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define XDZR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet during reset.
`define XDZR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/xdzr_pkg.sv
// Shared types and constants for the XOR-delta zero-run encoder.
// No dependencies; used by every module in rtl/.
package xdzr_pkg;

	localparam int unsigned RUN_LIMIT   = 65535;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = $clog2(QDEPTH);
	localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] ZERO_MARK = 8'h00;

	// Output byte slots of one command.
	localparam logic [1:0] PH_MARK = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_LIT  = 2'd3;

	// One classified request: an optional run flush followed by an optional literal.
	typedef struct packed {
		logic               has_run;
		logic [COUNT_W-1:0] run_count;
		logic               has_lit;
		logic [BYTE_W-1:0]  lit;
		logic               frame_end;
	} cmd_t;

endpackage

### rtl/xdzr_front.sv
// Front end: accepts requests, XORs the bytes, tracks the zero run and emits commands.
// Depends on xdzr_pkg and the assertion header.
`include "xor_delta_zero_run_encoder_assert.svh"

module xdzr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [xdzr_pkg::BYTE_W-1:0] cur_byte,
	input  logic [xdzr_pkg::BYTE_W-1:0] prev_byte,
	input  logic                        frame_end,
	output logic                        push,
	output xdzr_pkg::cmd_t              cmd
);

	logic [xdzr_pkg::COUNT_W-1:0] zero_run_count_q;
	logic [xdzr_pkg::COUNT_W-1:0] count_inc;
	logic [xdzr_pkg::COUNT_W-1:0] count_next;
	logic [xdzr_pkg::BYTE_W-1:0]  diff;
	logic                         hit_limit;

	assign diff      = cur_byte ^ prev_byte;
	assign count_inc = zero_run_count_q + 1'b1;
	assign hit_limit = (count_inc >= xdzr_pkg::COUNT_W'(xdzr_pkg::RUN_LIMIT));

	always_comb begin
		cmd.frame_end = frame_end;
		cmd.lit       = diff;
		if (diff == xdzr_pkg::ZERO_MARK) begin
			cmd.has_run   = hit_limit | frame_end;
			cmd.run_count = count_inc;
			cmd.has_lit   = 1'b0;
			count_next    = (hit_limit | frame_end) ? '0 : count_inc;
		end else begin
			cmd.has_run   = (zero_run_count_q != '0);
			cmd.run_count = zero_run_count_q;
			cmd.has_lit   = 1'b1;
			count_next    = '0;
		end
	end

	// drop requests that only extend an open run
	assign push = accept & (cmd.has_run | cmd.has_lit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_count_q <= '0;
		end else if (accept) begin
			zero_run_count_q <= count_next;
		end
	end

	`XDZR_ASSERT_NOW(a_count_below_limit, 1'b1,
		zero_run_count_q < xdzr_pkg::COUNT_W'(xdzr_pkg::RUN_LIMIT),
		"zero run count rests at or above the limit")

endmodule

### rtl/xdzr_fifo.sv
// Short command queue between front and back end, flip-flop storage.
// Depends on xdzr_pkg and the assertion header.
`include "xor_delta_zero_run_encoder_assert.svh"

module xdzr_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xdzr_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output xdzr_pkg::cmd_t rd_cmd
);

	xdzr_pkg::cmd_t              entry_q [xdzr_pkg::QDEPTH];
	logic [xdzr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [xdzr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [xdzr_pkg::QCNT_W-1:0] count_q;

	assign full      = (count_q == xdzr_pkg::QCNT_W'(xdzr_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = entry_q[rd_ptr_q];

	function automatic logic [xdzr_pkg::QPTR_W-1:0] ptr_inc(
		input logic [xdzr_pkg::QPTR_W-1:0] p
	);
		if (p == xdzr_pkg::QPTR_W'(xdzr_pkg::QDEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`XDZR_ASSERT_NOW(a_no_push_full, push, !full, "push into a full command queue")
	`XDZR_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "pop from an empty command queue")

endmodule

### rtl/xdzr_back.sv
// Back end: expands one command into output bytes, one per cycle while out_stall is low, into the output register.
// Depends on xdzr_pkg and the assertion header.
`include "xor_delta_zero_run_encoder_assert.svh"

module xdzr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  xdzr_pkg::cmd_t              cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [xdzr_pkg::BYTE_W-1:0] out_byte,
	output logic                        item_last,
	output logic                        frame_done
);

	logic [1:0]                  phase_q;
	logic                        out_valid_q;
	logic [xdzr_pkg::BYTE_W-1:0] out_byte_q;
	logic                        item_last_q;
	logic                        frame_done_q;
	logic                        load;
	logic                        is_last;
	logic [xdzr_pkg::BYTE_W-1:0] sel_byte;

	always_comb begin
		if (cmd.has_run) begin
			case (phase_q)
				xdzr_pkg::PH_MARK: sel_byte = xdzr_pkg::ZERO_MARK;
				xdzr_pkg::PH_LO:   sel_byte = cmd.run_count[xdzr_pkg::BYTE_W-1:0];
				xdzr_pkg::PH_HI:   sel_byte = cmd.run_count[xdzr_pkg::COUNT_W-1:xdzr_pkg::BYTE_W];
				default:           sel_byte = cmd.lit;
			endcase
			is_last = cmd.has_lit ? (phase_q == xdzr_pkg::PH_LIT) : (phase_q == xdzr_pkg::PH_HI);
		end else begin
			sel_byte = cmd.lit;
			is_last  = 1'b1;
		end
	end

	assign load = cmd_valid & (~out_valid_q | ~out_stall);
	assign pop  = load & is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= xdzr_pkg::PH_MARK;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= is_last ? xdzr_pkg::PH_MARK : phase_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= sel_byte;
			item_last_q  <= is_last;
			frame_done_q <= is_last & cmd.frame_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign item_last  = item_last_q;
	assign frame_done = frame_done_q;

	`XDZR_ASSERT_NOW(a_done_is_last, out_valid_q && frame_done_q, item_last_q,
		"frame_done without item_last")
	`XDZR_ASSERT_NOW(a_phase_idle, !cmd_valid, phase_q == xdzr_pkg::PH_MARK,
		"phase left mid-command with no command pending")
	`XDZR_ASSERT_NEXT(a_pop_restarts, pop, phase_q == xdzr_pkg::PH_MARK,
		"phase not restarted after finishing a command")

endmodule

### rtl/xor_delta_zero_run_encoder.sv
// XOR-delta zero-run encoder, top level. Uses xdzr_pkg, xdzr_front, xdzr_fifo, xdzr_back.
// A request reaches out_valid through the command queue, then the output register.
// Throughput: one request per cycle while requests give zero or one byte, in_stall low;
//   a run flush occupies the single-byte back end for three bytes, four with a literal.
// The four-entry command queue absorbs flush bursts; in_stall rises only when it fills.
// Reset (arst_n low, asynchronous): clears the run count, queue pointers and out_valid.
module xor_delta_zero_run_encoder (
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] cur_byte,
	input  logic [7:0] prev_byte,
	input  logic       frame_end,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       item_last,
	output logic       frame_done
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;
	xdzr_pkg::cmd_t wr_cmd;
	xdzr_pkg::cmd_t rd_cmd;

	// Hold requests off only while the queue has no room; the front itself never stalls.
	assign in_stall = q_full;
	assign accept   = in_valid & ~in_stall;

	// Classify: XOR, extend or close the zero run, pick flush and literal.
	xdzr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cur_byte  (cur_byte),
		.prev_byte (prev_byte),
		.frame_end (frame_end),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// Decouple the front, which never stalls, from the multi-byte back end.
	xdzr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rd_cmd    (rd_cmd)
	);

	// Advance through marker, count bytes and literal into the output register.
	xdzr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_not_empty),
		.cmd        (rd_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.item_last  (item_last),
		.frame_done (frame_done)
	);

endmodule
